[rtl/tcre_pkg.sv]
// Shared types, constants and helpers for the two-choice random evictor.
// Used by every module of the block but tcre_ram; depends on nothing.
package tcre_pkg;

    localparam int SLOTS    = 64;
    localparam int ID_COUNT = 256;
    localparam int ID_W     = 8;
    localparam int IDX_W    = $clog2(ID_COUNT);
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int OCC_W    = $clog2(SLOTS + 1);
    localparam int DRAW_W   = 64;
    localparam int TIME_W   = 32;
    localparam int SIZE_W   = 32;
    localparam int WANT_W   = 40;
    localparam int CNT_W    = 7;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_ERASE  = 3'd1;
    localparam logic [2:0] MODE_TOUCH  = 3'd2;
    localparam logic [2:0] MODE_EVICT  = 3'd3;
    localparam logic [2:0] MODE_EXPIRE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_DUP     = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ID_W-1:0]   entry_id;
        logic [SIZE_W-1:0] entry_size;
        logic [TIME_W-1:0] access_time;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] expire_after;
        logic [CNT_W-1:0]  check_budget;
        logic [WANT_W-1:0] need_bytes;
        logic [CNT_W-1:0]  need_files;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   victim_id;
        logic [SIZE_W-1:0] victim_bytes;
        logic              victim_valid;
        logic [1:0]        status;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic load;        // latch accepted item
        logic simple;      // id-mode result and table update
        logic set_s_pos;   // take target's slot from slot_of_entry
        logic rd_last;     // read last occupied slot
        logic rm_wr;       // close the gap, drop one entry
        logic ev_init;
        logic draw_i;      // advance generator, start mod n
        logic take_i;      // keep i, advance generator, start mod n-1
        logic take_j;      // form j, read slot i
        logic cap_ia;      // keep id at slot i, read slot j and atime
        logic cap_ib;      // keep atime a, read slot j again and its atime
        logic pick;        // pick older of the two
        logic set_s_zero;
        logic rd_slot_s;
        logic cap_v;
        logic cap_bytes;
        logic push;        // park victim, forward the parked one
        logic ex_init;
        logic rd_slot_scan;
        logic cap_scan;
        logic scan_inc;
        logic flush;       // final result of the item
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       simple_ok;
        logic       ev_go;
        logic       occ_one;
        logic       ex_go;
        logic       expired;
        logic       mod_busy;
        logic       pend_has;
        logic       out_busy;
    } t_dp_stat;

    function automatic logic [DRAW_W-1:0] xs_next(input logic [DRAW_W-1:0] x);
        logic [DRAW_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 7);
        y = y ^ (y << 17);
        return y;
    endfunction

endpackage

[rtl/tcre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcre_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/tcre_mod.sv]
// Bit-serial remainder unit: 64-bit draw modulo a small divisor, one bit a cycle.
// Depends on tcre_pkg.
module tcre_mod
    import tcre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DRAW_W-1:0] i_dividend,
    input  logic [OCC_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [OCC_W-1:0]  o_rem
);
    localparam int STEP_W = $clog2(DRAW_W);

    logic [DRAW_W-1:0] r_dvd;
    logic [OCC_W-1:0]  r_div;
    logic [OCC_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic [OCC_W:0]    w_trial;
    logic [OCC_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DRAW_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = OCC_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = OCC_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_dvd  <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(DRAW_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;
endmodule

[rtl/tcre_dp.sv]
// Datapath: slot table, per-id stores, generator, work counters, result registers.
// Depends on tcre_pkg, tcre_ram and tcre_mod.
module tcre_dp
    import tcre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DRAW_W-1:0] i_cfg_wdata,
    input  t_in_item          i_in_item,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_out_item         o_out_item
);
    t_in_item          r_item;
    logic [OCC_W-1:0]  r_occ;
    logic [DRAW_W-1:0] r_rng;
    logic [WANT_W-1:0] r_fb;
    logic [CNT_W-1:0]  r_fc;
    logic [OCC_W-1:0]  r_scan;
    logic [CNT_W-1:0]  r_chk;
    logic [SLOT_W-1:0] r_i, r_j, r_s;
    logic [ID_W-1:0]   r_ia, r_v;
    logic [TIME_W-1:0] r_ta;
    logic [SIZE_W-1:0] r_vb;
    t_out_item         r_pend;
    logic              r_pend_has;
    t_out_item         r_out;
    logic              r_out_valid;
    logic              r_present [ID_COUNT];

    logic [ID_W-1:0]   w_slot_rd;
    logic [SLOT_W-1:0] w_pos_rd;
    logic [TIME_W-1:0] w_at_rd;
    logic [SIZE_W-1:0] w_by_rd;
    logic              w_mod_busy;
    logic [OCC_W-1:0]  w_rem;
    logic [DRAW_W-1:0] w_draw;
    logic [IDX_W-1:0]  w_idx;
    logic              w_known, w_pres;
    logic [1:0]        w_st;
    logic              w_ins, w_touch;

    logic              w_slot_we, w_pos_we, w_at_we, w_by_we;
    logic [SLOT_W-1:0] w_slot_wa, w_slot_ra;
    logic [ID_W-1:0]   w_slot_wd;
    logic [IDX_W-1:0]  w_pos_wa, w_at_ra, w_by_ra;
    logic [SLOT_W-1:0] w_pos_wd;
    logic [OCC_W-1:0]  w_mod_div;
    logic [OCC_W-1:0]  w_jraw;
    logic [TIME_W:0]   w_deadline;

    assign w_draw  = xs_next(r_rng);
    assign w_idx   = IDX_W'(r_item.entry_id);
    assign w_known = ({1'b0, r_item.entry_id} < (ID_W + 1)'(ID_COUNT));
    assign w_pres  = r_present[w_idx];

    always_comb begin
        w_st = ST_OK;
        if (!w_known) begin
            w_st = ST_UNKNOWN;
        end else begin
            case (r_item.mode)
                MODE_INSERT: begin
                    if (w_pres) w_st = ST_DUP;
                    else if (r_occ >= OCC_W'(SLOTS)) w_st = ST_FULL;
                end
                MODE_ERASE, MODE_TOUCH: begin
                    if (!w_pres) w_st = ST_UNKNOWN;
                end
                default: w_st = ST_OK;
            endcase
        end
    end

    assign w_ins   = i_cmd.simple && (w_st == ST_OK) && (r_item.mode == MODE_INSERT);
    assign w_touch = i_cmd.simple && (w_st == ST_OK) && (r_item.mode == MODE_TOUCH);

    // write ports
    assign w_slot_we = w_ins || i_cmd.rm_wr;
    assign w_slot_wa = w_ins ? SLOT_W'(r_occ) : r_s;
    assign w_slot_wd = w_ins ? r_item.entry_id : w_slot_rd;
    assign w_pos_we  = w_ins || i_cmd.rm_wr;
    assign w_pos_wa  = w_ins ? w_idx : IDX_W'(w_slot_rd);
    assign w_pos_wd  = w_ins ? SLOT_W'(r_occ) : r_s;
    assign w_at_we   = w_ins || w_touch;
    assign w_by_we   = w_ins;

    // read ports; hold slot j on the read port until the pick
    always_comb begin
        w_slot_ra = '0;
        if (i_cmd.rd_last)      w_slot_ra = SLOT_W'(r_occ - 1'b1);
        if (i_cmd.rd_slot_s)    w_slot_ra = r_s;
        if (i_cmd.take_j)       w_slot_ra = r_i;
        if (i_cmd.cap_ia)       w_slot_ra = r_j;
        if (i_cmd.cap_ib)       w_slot_ra = r_j;
        if (i_cmd.rd_slot_scan) w_slot_ra = SLOT_W'(r_scan);
    end
    assign w_at_ra   = IDX_W'(w_slot_rd);
    assign w_by_ra   = IDX_W'(r_v);
    assign w_mod_div = i_cmd.take_i ? (r_occ - 1'b1) : r_occ;
    assign w_jraw    = w_rem;

    tcre_ram #(.W(ID_W), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(w_slot_we), .i_waddr(w_slot_wa), .i_wdata(w_slot_wd),
        .i_raddr(w_slot_ra), .o_rdata(w_slot_rd)
    );
    tcre_ram #(.W(SLOT_W), .DEPTH(ID_COUNT)) u_pos_ram (
        .i_clk(i_clk), .i_we(w_pos_we), .i_waddr(w_pos_wa), .i_wdata(w_pos_wd),
        .i_raddr(w_idx), .o_rdata(w_pos_rd)
    );
    tcre_ram #(.W(TIME_W), .DEPTH(ID_COUNT)) u_atime_ram (
        .i_clk(i_clk), .i_we(w_at_we), .i_waddr(w_idx), .i_wdata(r_item.access_time),
        .i_raddr(w_at_ra), .o_rdata(w_at_rd)
    );
    tcre_ram #(.W(SIZE_W), .DEPTH(ID_COUNT)) u_bytes_ram (
        .i_clk(i_clk), .i_we(w_by_we), .i_waddr(w_idx), .i_wdata(r_item.entry_size),
        .i_raddr(w_by_ra), .o_rdata(w_by_rd)
    );

    tcre_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_cmd.draw_i || i_cmd.take_i),
        .i_dividend(w_draw), .i_divisor(w_mod_div),
        .o_busy(w_mod_busy), .o_rem(w_rem)
    );

    assign w_deadline = {1'b0, w_at_rd} + {1'b0, r_item.expire_after};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_rng       <= DRAW_W'(1);
            r_fb        <= '0;
            r_fc        <= '0;
            r_scan      <= '0;
            r_chk       <= '0;
            r_pend_has  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ID_COUNT; k++) begin
                r_present[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_rng <= (i_cfg_wdata == '0) ? DRAW_W'(1) : i_cfg_wdata;
            end else if (i_cmd.draw_i || i_cmd.take_i) begin
                r_rng <= w_draw;
            end
            if (i_cmd.load) r_item <= i_in_item;
            if (i_cmd.simple) begin
                r_pend     <= '{victim_id: r_item.entry_id, victim_bytes: '0,
                                victim_valid: 1'b0, status: w_st, last: 1'b0};
                r_pend_has <= 1'b1;
            end
            if (w_ins) begin
                r_present[w_idx] <= 1'b1;
                r_occ            <= r_occ + 1'b1;
            end
            if (i_cmd.set_s_pos) begin
                r_s <= w_pos_rd;
                r_v <= r_item.entry_id;
            end
            if (i_cmd.rm_wr) begin
                r_present[IDX_W'(r_v)] <= 1'b0;
                r_occ                  <= r_occ - 1'b1;
            end
            if (i_cmd.ev_init) begin
                r_fb <= '0;
                r_fc <= '0;
            end
            if (i_cmd.take_i) r_i <= SLOT_W'(w_rem);
            if (i_cmd.take_j) begin
                r_j <= (w_jraw >= OCC_W'(r_i)) ? SLOT_W'(w_jraw + 1'b1) : SLOT_W'(w_jraw);
            end
            if (i_cmd.cap_ia) r_ia <= w_slot_rd;
            if (i_cmd.cap_ib) r_ta <= w_at_rd;
            if (i_cmd.pick) begin
                // first sample wins ties
                if (r_ta <= w_at_rd) begin
                    r_s <= r_i;
                    r_v <= r_ia;
                end else begin
                    r_s <= r_j;
                    r_v <= w_slot_rd;
                end
            end
            if (i_cmd.set_s_zero) r_s <= '0;
            if (i_cmd.cap_v) r_v <= w_slot_rd;
            if (i_cmd.cap_bytes) begin
                r_vb <= w_by_rd;
                r_fb <= r_fb + WANT_W'(w_by_rd);
                r_fc <= r_fc + 1'b1;
            end
            if (i_cmd.ex_init) begin
                r_scan <= '0;
                r_chk  <= '0;
            end
            if (i_cmd.cap_scan) begin
                r_v   <= w_slot_rd;
                r_s   <= SLOT_W'(r_scan);
                r_chk <= r_chk + 1'b1;
            end
            if (i_cmd.scan_inc) r_scan <= r_scan + 1'b1;

            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.push) begin
                if (r_pend_has) begin
                    r_out       <= r_pend;
                    r_out_valid <= 1'b1;
                end
                r_pend     <= '{victim_id: r_v, victim_bytes: r_vb,
                                victim_valid: 1'b1, status: ST_OK, last: 1'b0};
                r_pend_has <= 1'b1;
            end
            if (i_cmd.flush) begin
                if (r_pend_has) begin
                    r_out <= '{victim_id: r_pend.victim_id,
                               victim_bytes: r_pend.victim_bytes,
                               victim_valid: r_pend.victim_valid,
                               status: r_pend.status, last: 1'b1};
                end else begin
                    r_out <= '{victim_id: '0, victim_bytes: '0, victim_valid: 1'b0,
                               status: ST_OK, last: 1'b1};
                end
                r_out_valid <= 1'b1;
                r_pend_has  <= 1'b0;
            end
        end
    end

    assign o_stat.mode      = r_item.mode;
    assign o_stat.simple_ok = (w_st == ST_OK);
    assign o_stat.ev_go     = ((r_fb < r_item.need_bytes) || (r_fc < r_item.need_files))
                              && (r_occ != '0);
    assign o_stat.occ_one   = (r_occ == OCC_W'(1));
    assign o_stat.ex_go     = (r_scan < r_occ) && (r_chk < r_item.check_budget);
    assign o_stat.expired   = (w_deadline <= {1'b0, r_item.now_time});
    assign o_stat.mod_busy  = w_mod_busy;
    assign o_stat.pend_has  = r_pend_has;
    assign o_stat.out_busy  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

[rtl/tcre_ctrl.sv]
// Sequencer for the evictor: steps each command through the datapath.
// Depends on tcre_pkg.
module tcre_ctrl
    import tcre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_DISP   = 20'h00002,
        S_ER_POS = 20'h00004,
        S_RM_RD  = 20'h00008,
        S_RM_WR  = 20'h00010,
        S_EV_CHK = 20'h00020,
        S_EV_MI  = 20'h00040,
        S_EV_MJ  = 20'h00080,
        S_EV_RI  = 20'h00100,
        S_EV_RJ  = 20'h00200,
        S_EV_CMP = 20'h00400,
        S_EV_V0  = 20'h00800,
        S_EV_V1  = 20'h01000,
        S_RD_B   = 20'h02000,
        S_CAP_B  = 20'h04000,
        S_PUSH   = 20'h08000,
        S_EX_CHK = 20'h10000,
        S_EX_RS  = 20'h20000,
        S_EX_RT  = 20'h40000,
        S_FLUSH  = 20'h80000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.mode)
                    MODE_EVICT: begin
                        o_cmd.ev_init = 1'b1;
                        n_state       = S_EV_CHK;
                    end
                    MODE_EXPIRE: begin
                        o_cmd.ex_init = 1'b1;
                        n_state       = S_EX_CHK;
                    end
                    default: begin
                        o_cmd.simple = 1'b1;
                        if (i_stat.mode == MODE_ERASE && i_stat.simple_ok) begin
                            n_state = S_ER_POS;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end
                endcase
            end
            S_ER_POS: begin
                o_cmd.set_s_pos = 1'b1;
                n_state         = S_RM_RD;
            end
            S_RM_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_RM_WR;
            end
            S_RM_WR: begin
                o_cmd.rm_wr = 1'b1;
                if (i_stat.mode == MODE_EVICT) n_state = S_EV_CHK;
                else if (i_stat.mode == MODE_EXPIRE) n_state = S_EX_CHK;
                else n_state = S_FLUSH;
            end
            S_EV_CHK: begin
                if (!i_stat.ev_go) begin
                    n_state = S_FLUSH;
                end else if (i_stat.occ_one) begin
                    o_cmd.set_s_zero = 1'b1;
                    n_state          = S_EV_V0;
                end else begin
                    o_cmd.draw_i = 1'b1;
                    n_state      = S_EV_MI;
                end
            end
            S_EV_MI: begin
                if (!i_stat.mod_busy) begin
                    o_cmd.take_i = 1'b1;
                    n_state      = S_EV_MJ;
                end
            end
            S_EV_MJ: begin
                if (!i_stat.mod_busy) begin
                    o_cmd.take_j = 1'b1;
                    n_state      = S_EV_RI;
                end
            end
            S_EV_RI: begin
                o_cmd.cap_ia = 1'b1;
                n_state      = S_EV_RJ;
            end
            S_EV_RJ: begin
                o_cmd.cap_ib = 1'b1;
                n_state      = S_EV_CMP;
            end
            S_EV_CMP: begin
                o_cmd.pick = 1'b1;
                n_state    = S_RD_B;
            end
            S_EV_V0: begin
                o_cmd.rd_slot_s = 1'b1;
                n_state         = S_EV_V1;
            end
            S_EV_V1: begin
                o_cmd.cap_v = 1'b1;
                n_state     = S_RD_B;
            end
            S_RD_B: begin
                n_state = S_CAP_B;
            end
            S_CAP_B: begin
                o_cmd.cap_bytes = 1'b1;
                n_state         = S_PUSH;
            end
            S_PUSH: begin
                if (!(i_stat.pend_has && i_stat.out_busy)) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_RM_RD;
                end
            end
            S_EX_CHK: begin
                if (!i_stat.ex_go) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.rd_slot_scan = 1'b1;
                    n_state            = S_EX_RS;
                end
            end
            S_EX_RS: begin
                o_cmd.cap_scan = 1'b1;
                n_state        = S_EX_RT;
            end
            S_EX_RT: begin
                if (i_stat.expired) begin
                    n_state = S_CAP_B;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_EX_CHK;
                end
            end
            S_FLUSH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[rtl/two_choice_random_evictor.sv]
// Top level of the two-choice random evictor: sequencer plus datapath.
// Depends on tcre_pkg, tcre_ctrl and tcre_dp.
//
//   channel   direction  handshake                     payload
//   in        input      i_in_valid / o_in_ready       i_in_item (t_in_item)
//   out       output     o_out_valid / i_out_ready     o_out_item (t_out_item)
//   cfg       input      i_cfg_we, no wait             i_cfg_wdata (random_seed)
//
// With two or more entries resident, each evict victim takes two bit-serial
// remainders, each followed by taking the result, then slot and atime reads
// in turn; with one resident, the single slot is read directly.
// Each expire check reads a slot and its atime; an expired entry is dropped.
// One item is worked on at a time; the next is taken once the final transfer
// is staged in the output register.
// Reset is synchronous and active low; no clearing pass.
// A stalled output holds the sequencer at the point where it has a result
// to stage; otherwise the sequencer waits only on the remainder unit.
module two_choice_random_evictor
    import tcre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DRAW_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: one state per table access or wait
    tcre_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    // datapath: stores, generator, remainder unit, parked and output results
    tcre_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_item(i_in_item), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid), .o_out_item(o_out_item)
    );
endmodule

[rtl/tcre_chk.sv]
// Port-level checks for the evictor, bound to the top level.
// Depends on tcre_pkg.
module tcre_chk
    import tcre_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_item
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    // non-victim results are always final
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.victim_valid |-> o_out_item.last)
        else $error("non-victim result not last");

    // errors come alone, never with a victim
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |->
            !o_out_item.victim_valid && o_out_item.last)
        else $error("error status with victim or not last");
endmodule

bind two_choice_random_evictor tcre_chk u_tcre_chk (.*);
